/* design/scd_pkg.sv */
package scd_pkg;

   // Input transaction: one received byte plus the store status
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       store_busy;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tx_byte;
      logic [2:0]  slot;
      logic [31:0] word;
      logic [5:0]  point_index;
      logic        last;
   } rsp_type;

   // Work handed from the parser to the result sequencer
   typedef enum logic [1:0] {
      JOB_PROBE,
      JOB_OPEN,
      JOB_CTRL,
      JOB_POINT
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [31:0] word;
      logic [2:0]  slot;
      logic [5:0]  point_index;
      logic [3:0]  tens;
      logic [3:0]  units;
      logic        ends;
   } job_type;

   // Result kinds
   localparam logic [2:0] KIND_REPLY = 3'd0;
   localparam logic [2:0] KIND_OPEN  = 3'd1;
   localparam logic [2:0] KIND_CTRL  = 3'd2;
   localparam logic [2:0] KIND_POINT = 3'd3;
   localparam logic [2:0] KIND_READY = 3'd4;

   // Received byte codes
   localparam logic [7:0] CODE_PROBE  = 8'hC0;
   localparam logic [7:0] CODE_SKIP_A = 8'hE0;
   localparam logic [7:0] CODE_SKIP_B = 8'hD0;
   localparam logic [7:0] CODE_OPEN   = 8'hD1;
   localparam logic [7:0] CODE_CTRL0  = 8'hD2;
   localparam logic [7:0] CODE_CTRL7  = 8'hD9;
   localparam logic [7:0] CODE_POINT  = 8'hDA;
   localparam logic [7:0] CODE_NONE   = 8'h00;

   // Payload framing
   localparam logic [2:0] PAYLOAD_BYTES = 3'd5;
   localparam logic [2:0] SKIP_BYTES    = 3'd1;

   // Reply characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_W     = 8'h77;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] REPLY_TAG  = 8'h03;

   // Result sequence positions
   localparam logic [4:0] STEP_PROBE_LAST = 5'd7;
   localparam logic [4:0] STEP_POINT_LAST = 5'd8;
   localparam logic [4:0] STEP_READY      = 5'd9;
   localparam logic [4:0] STEP_END_LAST   = 5'd17;

endpackage

/* design/scd_front.sv */
module scd_front #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  scd_pkg::req_type req_data,
   output logic             job_valid,
   output scd_pkg::job_type job
);

   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [31:0] accumulator_ff, accumulator_in;
   logic [7:0]  command_code_ff, command_code_in;
   logic        session_open_ff, session_open_in;
   logic [6:0]  point_counter_ff, point_counter_in;
   logic [6:0]  session_length_ff, session_length_in;

   logic [2:0]  bytes_dec;
   logic [4:0]  shift;
   logic [31:0] word_sum;
   logic [7:0]  byte_in;
   logic [14:0] tens_prod;
   logic [3:0]  quot;
   logic [7:0]  quot_ten;
   logic [7:0]  point_next;

   assign byte_in    = req_data.rx_byte;
   assign bytes_dec  = bytes_left_ff - 3'd1;
   assign point_next = {1'b0, point_counter_ff} + 8'd1;

   // Place the low seven bits of the byte at its group position
   always_comb begin
      unique case (bytes_dec)
         3'd4:    shift = 5'd28;
         3'd3:    shift = 5'd21;
         3'd2:    shift = 5'd14;
         3'd1:    shift = 5'd7;
         default: shift = 5'd0;
      endcase
   end

   assign word_sum = accumulator_ff + ({25'd0, byte_in[6:0]} << shift);

   // Split the point number into decimal digits (exact for values below 128)
   assign tens_prod = 15'({8'd0, point_counter_ff} * 15'd205);
   assign quot      = tens_prod[14:11];
   assign quot_ten  = {4'd0, quot} * 8'd10;

   // Parse the byte and decide the work for the back end
   always_comb begin
      bytes_left_in     = bytes_left_ff;
      accumulator_in    = accumulator_ff;
      command_code_in   = command_code_ff;
      session_open_in   = session_open_ff;
      point_counter_in  = point_counter_ff;
      session_length_in = session_length_ff;
      job_valid         = 1'b0;
      job.op            = scd_pkg::JOB_PROBE;
      job.word          = word_sum;
      job.slot          = 3'(command_code_ff - scd_pkg::CODE_CTRL0);
      job.point_index   = point_counter_ff[5:0];
      job.units         = 4'(8'({1'b0, point_counter_ff}) - quot_ten);
      job.tens          = (quot >= 4'd10) ? quot - 4'd10 : quot;
      job.ends          = point_next >= {1'b0, session_length_ff};

      if (bytes_left_ff == 3'd0) begin
         priority if (byte_in == scd_pkg::CODE_PROBE) begin
            job_valid = 1'b1;
         end else if (byte_in == scd_pkg::CODE_SKIP_A || byte_in == scd_pkg::CODE_SKIP_B) begin
            bytes_left_in = scd_pkg::SKIP_BYTES;
         end else if (byte_in >= scd_pkg::CODE_OPEN && byte_in <= scd_pkg::CODE_POINT) begin
            command_code_in = byte_in;
            bytes_left_in   = scd_pkg::PAYLOAD_BYTES;
         end else begin
            bytes_left_in = 3'd0;
         end
      end else begin
         bytes_left_in  = bytes_dec;
         accumulator_in = word_sum;
         if (bytes_dec == 3'd0) begin
            // Act on the completed payload, then clear it
            accumulator_in  = '0;
            command_code_in = scd_pkg::CODE_NONE;
            priority if (command_code_ff == scd_pkg::CODE_OPEN) begin
               if (!req_data.store_busy) begin
                  session_open_in   = 1'b1;
                  session_length_in = (word_sum > 32'(MAX_POINTS)) ? 7'(MAX_POINTS)
                                                                   : word_sum[6:0];
                  point_counter_in  = '0;
                  job_valid         = 1'b1;
                  job.op            = scd_pkg::JOB_OPEN;
               end else begin
                  session_open_in = 1'b0;
               end
            end else if (command_code_ff >= scd_pkg::CODE_CTRL0
                         && command_code_ff <= scd_pkg::CODE_CTRL7) begin
               job_valid = session_open_ff;
               job.op    = scd_pkg::JOB_CTRL;
            end else if (command_code_ff == scd_pkg::CODE_POINT) begin
               job_valid = session_open_ff;
               job.op    = scd_pkg::JOB_POINT;
               if (session_open_ff) begin
                  point_counter_in = point_next[6:0];
                  if (job.ends) begin
                     session_open_in = 1'b0;
                  end
               end
            end else begin
               job_valid = 1'b0;
            end
         end
      end
   end

   // Hold parser state; advance only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff     <= '0;
         accumulator_ff    <= '0;
         command_code_ff   <= '0;
         session_open_ff   <= 1'b0;
         point_counter_ff  <= '0;
         session_length_ff <= '0;
      end else if (accept) begin
         bytes_left_ff     <= bytes_left_in;
         accumulator_ff    <= accumulator_in;
         command_code_ff   <= command_code_in;
         session_open_ff   <= session_open_in;
         point_counter_ff  <= point_counter_in;
         session_length_ff <= session_length_in;
      end
   end

endmodule

/* design/scd_job_queue.sv */
module scd_job_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scd_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output scd_pkg::job_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   scd_pkg::job_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("job queue count above depth");
   assert property (@(posedge clock) disable iff (reset) pop |-> count_ff != '0)
      else $error("job queue popped while empty");
`endif

endmodule

/* design/scd_back.sv */
module scd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  scd_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output scd_pkg::rsp_type rsp_data
);

   scd_pkg::job_type cur_ff;
   logic             cur_valid_ff;
   logic [4:0]       step_ff;
   scd_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff;

   logic             out_free;
   logic             advance;
   logic             step_last;
   logic             cur_done;

   // Reply frame: four zero bytes, a tag, then three characters
   function automatic logic [7:0] reply_byte(input logic [2:0] idx, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c);
      logic [7:0] r;
      unique case (idx)
         3'd4:    r = scd_pkg::REPLY_TAG;
         3'd5:    r = a;
         3'd6:    r = b;
         3'd7:    r = c;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   assign out_free  = !out_valid_ff || rsp_pop;
   assign advance   = cur_valid_ff && out_free;
   assign cur_done  = advance && step_last;
   assign job_pop   = job_valid && (!cur_valid_ff || cur_done);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Build the result for the current step of the job
   always_comb begin
      logic [7:0] digit_t;
      logic [7:0] digit_u;
      digit_t   = scd_pkg::CHAR_ZERO + {4'd0, cur_ff.tens};
      digit_u   = scd_pkg::CHAR_ZERO + {4'd0, cur_ff.units};
      out_in    = '0;
      step_last = 1'b0;
      unique case (cur_ff.op)
         scd_pkg::JOB_PROBE: begin
            out_in.kind    = scd_pkg::KIND_REPLY;
            out_in.tx_byte = reply_byte(step_ff[2:0], scd_pkg::CHAR_U, scd_pkg::CHAR_W,
                                        scd_pkg::CHAR_U);
            step_last      = step_ff == scd_pkg::STEP_PROBE_LAST;
         end
         scd_pkg::JOB_OPEN: begin
            out_in.kind = scd_pkg::KIND_OPEN;
            out_in.word = cur_ff.word;
            step_last   = 1'b1;
         end
         scd_pkg::JOB_CTRL: begin
            out_in.kind = scd_pkg::KIND_CTRL;
            out_in.slot = cur_ff.slot;
            out_in.word = cur_ff.word;
            step_last   = 1'b1;
         end
         scd_pkg::JOB_POINT: begin
            step_last = cur_ff.ends ? step_ff == scd_pkg::STEP_END_LAST
                                    : step_ff == scd_pkg::STEP_POINT_LAST;
            priority if (step_ff == 5'd0) begin
               out_in.kind        = scd_pkg::KIND_POINT;
               out_in.word        = cur_ff.word;
               out_in.point_index = cur_ff.point_index;
            end else if (step_ff <= scd_pkg::STEP_POINT_LAST) begin
               out_in.kind    = scd_pkg::KIND_REPLY;
               out_in.tx_byte = reply_byte(3'(step_ff - 5'd1), scd_pkg::CHAR_EQUAL,
                                           digit_t, digit_u);
            end else if (step_ff == scd_pkg::STEP_READY) begin
               out_in.kind = scd_pkg::KIND_READY;
            end else begin
               out_in.kind    = scd_pkg::KIND_REPLY;
               out_in.tx_byte = reply_byte(3'(step_ff - 5'd10), scd_pkg::CHAR_O,
                                           scd_pkg::CHAR_K, scd_pkg::CHAR_BANG);
            end
         end
         default: begin
            out_in = '0;
         end
      endcase
      out_in.last = step_last;
   end

   // Load the next job, step through its results
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else if (job_pop) begin
         cur_valid_ff <= 1'b1;
         step_ff      <= '0;
      end else if (cur_done) begin
         cur_valid_ff <= 1'b0;
      end else if (advance) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
   end

   // Hold the result until popped
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> step_ff <= scd_pkg::STEP_END_LAST)
      else $error("result step past end of sequence");
   assert property (@(posedge clock) disable iff (reset)
      cur_done |=> out_valid_ff && out_ff.last)
      else $error("finished job did not leave a last result");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == scd_pkg::KIND_REPLY |-> out_ff.word == '0
                                                             && out_ff.slot == '0)
      else $error("reply byte carries payload fields");
`endif

endmodule

/* design/serial_command_deframer.sv */
// Channel | Direction | Handshake              | Payload
// req_    | in        | req_push / req_full    | req_data: rx_byte, store_busy
// rsp_    | out       | rsp_empty / rsp_pop    | rsp_data: kind, tx_byte, slot, word,
//         |           |                        |   point_index, last
//
// A byte is taken in every cycle while the job queue (QUEUE_DEPTH jobs) has room.
// Results leave the result sequencer one per cycle while rsp_pop is high: 8 for
// a probe, 1 for an open or control word, 9 for a point and 18 for the point that
// ends a session. Reset clears all control state; no clearing pass follows.
// rsp_pop low holds the result register; once the queue fills, req_full rises.
module serial_command_deframer #(
   parameter int MAX_POINTS  = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  scd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output scd_pkg::rsp_type rsp_data
);

   logic             accept;
   logic             job_valid;
   scd_pkg::job_type job;
   logic             head_valid;
   scd_pkg::job_type head_data;
   logic             head_pop;

   assign accept = req_push && !req_full;

   scd_front #(
      .MAX_POINTS(MAX_POINTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .job_valid(job_valid),
      .job      (job)
   );

   scd_job_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && job_valid),
      .push_data (job),
      .full      (req_full),
      .pop       (head_pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   scd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(head_valid),
      .job      (head_data),
      .job_pop  (head_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule
